FILE: hw/rtl/dnv_pkg.sv
`default_nettype none

package dnv_pkg;

   // Configuration register width and register indexes
   localparam int unsigned CFG_BITS = 8;
   localparam int unsigned CSR_INDEX_BITS = 1;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_MIN_LENGTH = 1'b0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_MAX_LENGTH = 1'b1;

   localparam logic [CFG_BITS-1:0] MIN_LENGTH_RESET = 8'd3;
   localparam logic [CFG_BITS-1:0] MAX_LENGTH_RESET = 8'd63;

   // Character codes
   localparam logic [7:0] CH_DOT    = 8'h2E;
   localparam logic [7:0] CH_HYPHEN = 8'h2D;
   localparam logic [7:0] CH_LOWER_A = 8'h61;
   localparam logic [7:0] CH_LOWER_Z = 8'h7A;
   localparam logic [7:0] CH_DIGIT_0 = 8'h30;
   localparam logic [7:0] CH_DIGIT_9 = 8'h39;

   // Class of one input character
   typedef struct packed {
      logic is_dot;
      logic is_hyphen;
      logic is_lower;
      logic is_digit;
   } char_class_type;

endpackage

`default_nettype wire

FILE: hw/rtl/dnv_char_class.sv
`default_nettype none

module dnv_char_class (
   input  wire logic [7:0]              char_byte,
   output dnv_pkg::char_class_type      char_class
);
   import dnv_pkg::*;

   // Decode the byte into the classes the grammar cares about
   always_comb begin
      char_class.is_dot    = (char_byte == CH_DOT);
      char_class.is_hyphen = (char_byte == CH_HYPHEN);
      char_class.is_lower  = (char_byte >= CH_LOWER_A) && (char_byte <= CH_LOWER_Z);
      char_class.is_digit  = (char_byte >= CH_DIGIT_0) && (char_byte <= CH_DIGIT_9);
   end

endmodule

`default_nettype wire

FILE: hw/rtl/dotted_name_validator.sv
`default_nettype none

// Channel   | ports                                   | direction
// ----------+-----------------------------------------+----------
// request   | req_valid, req_ready, req_char_byte,    | in
//           | req_last_byte                           |
// response  | rsp_valid, rsp_ready, rsp_name_valid    | out
// csr       | csr_write_en, csr_index, csr_wdata      | in
//
// One character per cycle while req_ready is high: each transaction updates
// the name and label counters in the cycle it is accepted; a name's verdict is
// loaded into the response register on its last byte and shows the cycle after.
// Reset restores min_length 3, max_length 63 and clears the name state.
// The single response register decouples the sides: a request is taken
// whenever that register is empty or is being emptied in the same cycle.

module dotted_name_validator #(
   parameter int unsigned COUNT_BITS = 8
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,

   input  wire logic                                 req_valid,
   output logic                                      req_ready,
   input  wire logic [7:0]                           req_char_byte,
   input  wire logic                                 req_last_byte,

   output logic                                      rsp_valid,
   input  wire logic                                 rsp_ready,
   output logic                                      rsp_name_valid,

   input  wire logic                                 csr_write_en,
   input  wire logic [dnv_pkg::CSR_INDEX_BITS-1:0]   csr_index,
   input  wire logic [dnv_pkg::CFG_BITS-1:0]         csr_wdata
);
   import dnv_pkg::*;

   localparam int unsigned CMP_BITS = (COUNT_BITS > CFG_BITS) ? COUNT_BITS : CFG_BITS;
   localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;
   localparam logic [COUNT_BITS-1:0] COUNT_ONE = COUNT_BITS'(1);

   logic [CFG_BITS-1:0]   min_length_ff;
   logic [CFG_BITS-1:0]   max_length_ff;

   logic [COUNT_BITS-1:0] name_length_ff, name_length_in;
   logic [COUNT_BITS-1:0] label_length_ff, label_length_in;
   logic                  prev_letdig_ff, prev_letdig_in;
   logic                  error_seen_ff, error_seen_in;

   logic                  rsp_valid_ff, rsp_valid_in;
   logic                  rsp_name_valid_ff, rsp_name_valid_in;

   char_class_type        char_class;
   logic                  letdig;
   logic                  accept;
   logic [CMP_BITS-1:0]   min_cmp;
   logic [CMP_BITS-1:0]   max_cmp;
   logic                  label_done_ok;
   logic                  label_end_ok;
   logic                  verdict;

   dnv_char_class u_char_class (
      .char_byte  (req_char_byte),
      .char_class (char_class)
   );

   // Write configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         min_length_ff <= MIN_LENGTH_RESET;
         max_length_ff <= MAX_LENGTH_RESET;
      end else if (csr_write_en) begin
         case (csr_index)
            CSR_MIN_LENGTH: min_length_ff <= csr_wdata;
            CSR_MAX_LENGTH: max_length_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // Take a request when the response register is free or draining
   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;

   assign letdig  = char_class.is_lower || char_class.is_digit;
   assign min_cmp = CMP_BITS'(min_length_ff);
   assign max_cmp = CMP_BITS'(max_length_ff);

   // Check the label that a dot closes
   assign label_done_ok = (label_length_ff != '0)
                          && (CMP_BITS'(label_length_ff) >= min_cmp)
                          && prev_letdig_ff;

   // Advance the per-name state for this character
   always_comb begin
      name_length_in = (name_length_ff == COUNT_MAX) ? name_length_ff
                                                     : name_length_ff + COUNT_ONE;
      error_seen_in  = error_seen_ff;
      if (char_class.is_dot) begin
         if (!label_done_ok) begin
            error_seen_in = 1'b1;
         end
         label_length_in = '0;
         prev_letdig_in  = 1'b0;
      end else begin
         if (label_length_ff == '0) begin
            if (!char_class.is_lower) begin
               error_seen_in = 1'b1;
            end
         end else if (!letdig && !char_class.is_hyphen) begin
            error_seen_in = 1'b1;
         end
         label_length_in = (label_length_ff == COUNT_MAX) ? label_length_ff
                                                          : label_length_ff + COUNT_ONE;
         prev_letdig_in  = letdig;
      end
   end

   // Final verdict on the updated state
   assign label_end_ok = (label_length_in != '0)
                         && (CMP_BITS'(label_length_in) >= min_cmp)
                         && prev_letdig_in;
   assign verdict = !error_seen_in && label_end_ok
                    && (CMP_BITS'(name_length_in) >= min_cmp)
                    && (CMP_BITS'(name_length_in) <= max_cmp);

   // Hold the per-name state; clear it after the last byte
   always_ff @(posedge clock) begin
      if (reset) begin
         name_length_ff  <= '0;
         label_length_ff <= '0;
         prev_letdig_ff  <= 1'b0;
         error_seen_ff   <= 1'b0;
      end else if (accept) begin
         if (req_last_byte) begin
            name_length_ff  <= '0;
            label_length_ff <= '0;
            prev_letdig_ff  <= 1'b0;
            error_seen_ff   <= 1'b0;
         end else begin
            name_length_ff  <= name_length_in;
            label_length_ff <= label_length_in;
            prev_letdig_ff  <= prev_letdig_in;
            error_seen_ff   <= error_seen_in;
         end
      end
   end

   // Load the response register on a last byte, drop it when taken
   always_comb begin
      rsp_valid_in      = rsp_valid_ff && !rsp_ready;
      rsp_name_valid_in = rsp_name_valid_ff;
      if (accept && req_last_byte) begin
         rsp_valid_in      = 1'b1;
         rsp_name_valid_in = verdict;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_name_valid_ff <= rsp_name_valid_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_name_valid = rsp_name_valid_ff;

endmodule

`default_nettype wire
